FILE: hw/rtl/gcl_pkg.sv
// Shared types and constants for the G-code line parser.
// Used by the scanner, the commit stage, the top level and the testbench.
`default_nettype none

package gcl_pkg;

  // Fraction digits kept for X and Y (thousandths when 3, legal range 0..6)
  localparam int FRAC_DIGITS = 3;
  localparam int FRAC_W = (FRAC_DIGITS > 0) ? $clog2(FRAC_DIGITS + 1) : 1;
  localparam int POW_W = $clog2((10 ** FRAC_DIGITS) + 1);
  localparam int PROD_W = 32 + POW_W;

  // Magnitude accumulator saturates at all ones
  localparam int ACC_W = 34;
  localparam logic [ACC_W-1:0] ACC_CAP = '1;

  localparam logic [32:0] WORD_POS_LIM = 33'h0_7FFF_FFFF;
  localparam logic [32:0] WORD_NEG_LIM = 33'h0_8000_0000;
  localparam logic [7:0] BYTE_LIM = 8'hFF;

  // Characters
  localparam logic [7:0] CH_G = 8'h47;
  localparam logic [7:0] CH_M = 8'h4D;
  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_9 = 8'h39;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR = 8'h0D;

  // Command letter codes
  localparam logic [1:0] LETTER_NONE = 2'd0;
  localparam logic [1:0] LETTER_G = 2'd1;
  localparam logic [1:0] LETTER_M = 2'd2;

  // Recognized command numbers
  localparam logic [7:0] CMD_G_MOVE = 8'd1;
  localparam logic [7:0] CMD_G_HOME = 8'd28;
  localparam logic [7:0] CMD_M_PEN = 8'd1;
  localparam logic [7:0] CMD_M_LASER = 8'd4;
  localparam logic [7:0] CMD_M_STOP = 8'd10;

  // Which held value a finished number goes to
  typedef enum logic [2:0] {
    CK_CMD,
    CK_X,
    CK_Y,
    CK_DELAY,
    CK_PEN,
    CK_LASER
  } commit_kind_t;

  // One item handed from the scanner to the commit stage
  typedef struct packed {
    logic emit;
    logic do_commit;
    commit_kind_t kind;
    logic [ACC_W-1:0] accum;
    logic neg;
    logic [FRAC_W-1:0] scale;
    logic [1:0] letter;
    logic [7:0] number;
  } req_t;

  typedef logic [FRAC_DIGITS:0][POW_W-1:0] pow_tab_t;

  function automatic pow_tab_t make_pow10_tab();
    pow_tab_t tab;
    int p;
    p = 1;
    for (int k = 0; k <= FRAC_DIGITS; k++) begin
      tab[k] = POW_W'(p);
      p = p * 10;
    end
    return tab;
  endfunction

  localparam pow_tab_t POW10_TAB = make_pow10_tab();

endpackage

`default_nettype wire

FILE: hw/rtl/gcl_char_if.sv
// Character channel: valid/ready handshake carrying one line character per item.
// Standalone; no package needed.
`default_nettype none

interface gcl_char_if;
  logic valid;
  logic ready;
  logic [7:0] char_code;
  logic last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink (input valid, input char_code, input last_char, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/gcl_result_if.sv
// Result channel: valid/ready handshake carrying all held values of one line.
// Standalone; no package needed.
`default_nettype none

interface gcl_result_if;
  logic valid;
  logic ready;
  logic [1:0] command_letter;
  logic [7:0] command_number;
  logic signed [31:0] target_x;
  logic signed [31:0] target_y;
  logic signed [31:0] aux_delay;
  logic [7:0] pen_position;
  logic [7:0] laser_power;
  logic overflow;

  modport source (
    output valid, output command_letter, output command_number,
    output target_x, output target_y, output aux_delay,
    output pen_position, output laser_power, output overflow,
    input ready
  );
  modport sink (
    input valid, input command_letter, input command_number,
    input target_x, input target_y, input aux_delay,
    input pen_position, input laser_power, input overflow,
    output ready
  );
endinterface

`default_nettype wire

FILE: hw/rtl/gcl_scanner.sv
// Character scanner: line phase machine, number accumulation, command decode.
// Depends on gcl_pkg and gcl_char_if; emits one request per accepted item.
`default_nettype none

module gcl_scanner (
  input  logic           clk,
  input  logic           rst,
  gcl_char_if.sink       chars,
  input  logic           req_take,
  output logic           req_valid,
  output gcl_pkg::req_t  req
);
  import gcl_pkg::*;

  localparam int SUM_W = ACC_W + 4;

  typedef enum logic [11:0] {
    PH_START      = 12'b0000_0000_0001,
    PH_IGNORE     = 12'b0000_0000_0010,
    PH_CMD        = 12'b0000_0000_0100,
    PH_X          = 12'b0000_0000_1000,
    PH_Y          = 12'b0000_0001_0000,
    PH_DELAY      = 12'b0000_0010_0000,
    PH_PEN        = 12'b0000_0100_0000,
    PH_LASER      = 12'b0000_1000_0000,
    PH_SKIP_X     = 12'b0001_0000_0000,
    PH_SKIP_Y     = 12'b0010_0000_0000,
    PH_SKIP_DELAY = 12'b0100_0000_0000,
    PH_DONE       = 12'b1000_0000_0000
  } phase_t;

  phase_t phase, phase_next;
  logic [ACC_W-1:0] accum, acc_next, acc_f, acc_capped;
  logic neg, neg_next, neg_f;
  logic [FRAC_W-1:0] frac, frac_next, frac_f;
  logic seen, seen_next, seen_f;
  logic begun, begun_next, begun_f;
  logic [1:0] letter, letter_next;
  logic [7:0] number, number_next;
  logic [SUM_W-1:0] acc_add;
  logic [3:0] digit;
  logic is_digit, is_blank, is_sign, is_point;
  logic in_num, decimal, consumed, do_commit, load;
  req_t req_next;

  assign load = chars.valid && chars.ready;
  assign chars.ready = !req_valid || req_take;

  assign digit = 4'(chars.char_code - CH_0);
  assign is_digit = (chars.char_code >= CH_0) && (chars.char_code <= CH_9);
  assign is_blank = (chars.char_code == CH_SPACE) ||
                    ((chars.char_code >= CH_TAB) && (chars.char_code <= CH_CR));
  assign is_sign = (chars.char_code == CH_PLUS) || (chars.char_code == CH_MINUS);
  assign is_point = (chars.char_code == CH_POINT);

  assign in_num = (phase == PH_CMD) || (phase == PH_X) || (phase == PH_Y) ||
                  (phase == PH_DELAY) || (phase == PH_PEN) || (phase == PH_LASER);
  assign decimal = (phase == PH_X) || (phase == PH_Y);

  // accum * 10 + digit, saturating
  assign acc_add = (SUM_W'(accum) << 3) + (SUM_W'(accum) << 1) + SUM_W'(digit);
  assign acc_capped = (|acc_add[SUM_W-1:ACC_W]) ? ACC_CAP : acc_add[ACC_W-1:0];

  // Number feed: values after this character (unchanged if it ends the number)
  always_comb begin
    acc_f = accum;
    neg_f = neg;
    frac_f = frac;
    seen_f = seen;
    begun_f = begun;
    consumed = 1'b0;
    priority if (is_digit) begin
      consumed = 1'b1;
      begun_f = 1'b1;
      if (!seen) begin
        acc_f = acc_capped;
      end else if (frac < FRAC_W'(FRAC_DIGITS)) begin
        acc_f = acc_capped;
        frac_f = frac + 1'b1;
      end
    end else if (!begun && is_blank) begin
      consumed = 1'b1;
    end else if (!begun && is_sign) begin
      consumed = 1'b1;
      begun_f = 1'b1;
      neg_f = (chars.char_code == CH_MINUS);
    end else if (decimal && is_point && !seen) begin
      consumed = 1'b1;
      begun_f = 1'b1;
      seen_f = 1'b1;
    end else begin
      consumed = 1'b0;
    end
  end

  // A number finishes on the character that ends it, or on line end
  assign do_commit = in_num && (!consumed || chars.last_char);

  always_comb begin
    phase_next = phase;
    letter_next = letter;
    number_next = number;
    acc_next = '0;
    neg_next = 1'b0;
    frac_next = '0;
    seen_next = 1'b0;
    begun_next = 1'b0;

    unique case (phase)
      PH_START: begin
        if (chars.char_code == CH_G) begin
          letter_next = LETTER_G;
          phase_next = PH_CMD;
        end else if (chars.char_code == CH_M) begin
          letter_next = LETTER_M;
          phase_next = PH_CMD;
        end else begin
          phase_next = PH_IGNORE;
        end
      end
      PH_CMD, PH_X, PH_Y, PH_DELAY, PH_PEN, PH_LASER: begin
        if (do_commit) begin
          unique case (phase)
            PH_CMD: begin
              phase_next = PH_DONE;
              // negative values clamp to zero, so only a positive exact match counts
              if (letter == LETTER_G) begin
                if (!neg_f && acc_f == ACC_W'(CMD_G_MOVE)) begin
                  number_next = CMD_G_MOVE;
                  phase_next = PH_SKIP_X;
                end else if (!neg_f && acc_f == ACC_W'(CMD_G_HOME)) begin
                  number_next = CMD_G_HOME;
                end
              end else if (letter == LETTER_M) begin
                if (!neg_f && acc_f == ACC_W'(CMD_M_PEN)) begin
                  number_next = CMD_M_PEN;
                  phase_next = PH_PEN;
                end else if (!neg_f && acc_f == ACC_W'(CMD_M_LASER)) begin
                  number_next = CMD_M_LASER;
                  phase_next = PH_LASER;
                end else if (!neg_f && acc_f == ACC_W'(CMD_M_STOP)) begin
                  number_next = CMD_M_STOP;
                end
              end
            end
            PH_X: phase_next = PH_SKIP_Y;
            PH_Y: phase_next = PH_SKIP_DELAY;
            default: phase_next = PH_DONE;
          endcase
        end else begin
          acc_next = acc_f;
          neg_next = neg_f;
          frac_next = frac_f;
          seen_next = seen_f;
          begun_next = begun_f;
        end
      end
      PH_SKIP_X: phase_next = PH_X;
      PH_SKIP_Y: phase_next = PH_Y;
      PH_SKIP_DELAY: phase_next = PH_DELAY;
      PH_IGNORE, PH_DONE: phase_next = phase;
      default: phase_next = PH_START;
    endcase

    if (chars.last_char) begin
      phase_next = PH_START;
      acc_next = '0;
      neg_next = 1'b0;
      frac_next = '0;
      seen_next = 1'b0;
      begun_next = 1'b0;
    end
  end

  always_comb begin
    req_next.emit = chars.last_char;
    req_next.do_commit = do_commit;
    req_next.accum = acc_f;
    req_next.neg = neg_f;
    req_next.scale = decimal ? (FRAC_W'(FRAC_DIGITS) - frac_f) : '0;
    req_next.letter = letter_next;
    req_next.number = number_next;
    unique case (phase)
      PH_X: req_next.kind = CK_X;
      PH_Y: req_next.kind = CK_Y;
      PH_DELAY: req_next.kind = CK_DELAY;
      PH_PEN: req_next.kind = CK_PEN;
      PH_LASER: req_next.kind = CK_LASER;
      default: req_next.kind = CK_CMD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      accum <= '0;
      neg <= 1'b0;
      frac <= '0;
      seen <= 1'b0;
      begun <= 1'b0;
      letter <= LETTER_NONE;
      number <= '0;
      req_valid <= 1'b0;
    end else if (load) begin
      phase <= phase_next;
      accum <= acc_next;
      neg <= neg_next;
      frac <= frac_next;
      seen <= seen_next;
      begun <= begun_next;
      letter <= letter_next;
      number <= number_next;
      req_valid <= 1'b1;
    end else if (req_take) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      req <= req_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/gcl_commit.sv
// Commit stage: scales and clamps finished numbers, keeps held values,
// and drives the result register. Depends on gcl_pkg and gcl_result_if.
`default_nettype none

module gcl_commit (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  gcl_pkg::req_t  req,
  output logic           req_take,
  gcl_result_if.source   results
);
  import gcl_pkg::*;

  logic signed [31:0] held_x, held_y, held_delay;
  logic signed [31:0] x_next, y_next, delay_next;
  logic [7:0] held_pen, held_laser, pen_next, laser_next;
  logic line_ovf;
  logic [PROD_W-1:0] prod;
  logic mag_hi, word_sat, byte_sat, is_word, sat;
  logic [31:0] word_val;
  logic [7:0] byte_val;

  // Items without a result drain even while the result register is stalled
  assign req_take = req_valid && (!req.emit || !results.valid || results.ready);

  assign mag_hi = |req.accum[ACC_W-1:32];
  assign prod = req.accum[31:0] * POW10_TAB[req.scale];

  always_comb begin
    word_sat = mag_hi || (req.neg ? (prod > PROD_W'(WORD_NEG_LIM))
                                  : (prod > PROD_W'(WORD_POS_LIM)));
    if (word_sat) begin
      word_val = req.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      word_val = req.neg ? (-prod[31:0]) : prod[31:0];
    end

    // byte fields: any negative nonzero value clamps to zero
    if (req.neg) begin
      byte_sat = mag_hi || (prod != '0);
      byte_val = '0;
    end else begin
      byte_sat = mag_hi || (prod > PROD_W'(BYTE_LIM));
      byte_val = byte_sat ? BYTE_LIM : prod[7:0];
    end

    is_word = (req.kind == CK_X) || (req.kind == CK_Y) || (req.kind == CK_DELAY);
    sat = req.do_commit && (is_word ? word_sat : byte_sat);

    x_next = held_x;
    y_next = held_y;
    delay_next = held_delay;
    pen_next = held_pen;
    laser_next = held_laser;
    if (req.do_commit) begin
      unique case (req.kind)
        CK_X: x_next = word_val;
        CK_Y: y_next = word_val;
        CK_DELAY: delay_next = word_val;
        CK_PEN: pen_next = byte_val;
        CK_LASER: laser_next = byte_val;
        default: x_next = held_x;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_x <= '0;
      held_y <= '0;
      held_delay <= '0;
      held_pen <= '0;
      held_laser <= '0;
      line_ovf <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      if (req_take) begin
        held_x <= x_next;
        held_y <= y_next;
        held_delay <= delay_next;
        held_pen <= pen_next;
        held_laser <= laser_next;
        line_ovf <= req.emit ? 1'b0 : (line_ovf || sat);
      end
      if (req_take && req.emit) begin
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_take && req.emit) begin
      results.command_letter <= req.letter;
      results.command_number <= req.number;
      results.target_x <= x_next;
      results.target_y <= y_next;
      results.aux_delay <= delay_next;
      results.pen_position <= pen_next;
      results.laser_power <= laser_next;
      results.overflow <= line_ovf || sat;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/gcode_line_parser_core.sv
// G-code line parser top level: scanner stage, then commit stage with result register.
// Throughput: one character item per cycle while the result register is not stalled; the result for a line
// passes through the scanner request register, then the result register.
// The number accumulator (multiply by ten and add) closes the per-character loop.
// Reset (synchronous, rst high): line start, all held values and flags cleared.
`default_nettype none

module gcode_line_parser_core (
  input  logic         clk,
  input  logic         rst,
  gcl_char_if.sink     chars,
  gcl_result_if.source results
);
  import gcl_pkg::*;

  logic req_valid;
  logic req_take;
  req_t req;

  gcl_scanner u_scanner (
    .clk       (clk),
    .rst       (rst),
    .chars     (chars),
    .req_take  (req_take),
    .req_valid (req_valid),
    .req       (req)
  );

  gcl_commit u_commit (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .req_take  (req_take),
    .results   (results)
  );

  // A line-ending item must reach the commit stage flagged to emit
  a_last_emits: assert property (@(posedge clk) disable iff (rst)
    chars.valid && chars.ready && chars.last_char |=> req_valid && req.emit)
    else $error("line end did not produce an emit request");

  // An emitting item taken by the commit stage shows up as a result
  a_emit_result: assert property (@(posedge clk) disable iff (rst)
    req_take && req.emit |=> results.valid)
    else $error("emit request taken without a result");

  // Only X and Y carry a fraction scale
  a_scale_decimal: assert property (@(posedge clk) disable iff (rst)
    req_valid && !(req.kind == CK_X || req.kind == CK_Y) |-> req.scale == '0)
    else $error("nonzero scale on an integer field");

endmodule

`default_nettype wire

FILE: tb/gcode_line_parser_core_tb.sv
// Self-checking bench for gcode_line_parser_core: streams command lines one character at a time.
// A line-level parser model predicts the held values; the result channel is checked in order.
// Depends on gcl_pkg, gcl_char_if and gcl_result_if from the RTL.
`default_nettype none

module gcode_line_parser_core_tb;
  import gcl_pkg::*;

  localparam int CHAR_TARGET = 1150;
  localparam int CALM_TAIL = 150;
  localparam int G_GAP = 2;
  localparam int M_GAP = 1;
  localparam longint WORD_MIN = -(longint'(1) <<< 31);
  localparam longint WORD_MAX = (longint'(1) <<< 31) - 1;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_X = 8'h58;
  localparam logic [7:0] CH_Y = 8'h59;
  localparam logic [7:0] CH_F = 8'h46;

  typedef enum logic [3:0] {
    PS_START, PS_IGNORE, PS_CMD, PS_X, PS_Y, PS_DELAY, PS_PEN, PS_LASER,
    PS_SKIP_X, PS_SKIP_Y, PS_SKIP_DELAY, PS_DONE
  } parse_state_t;

  typedef struct {
    logic [7:0] code;
    bit         last;
    bit         hold;
  } char_item_t;

  typedef struct {
    logic [1:0]  letter;
    logic [7:0]  number;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] delay;
    logic [7:0]  pen;
    logic [7:0]  laser;
    logic        ovf;
  } line_values_t;

  logic clk;
  logic rst;

  gcl_char_if   chars_if ();
  gcl_result_if res_if ();

  gcode_line_parser_core dut (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_if),
    .results (res_if)
  );

  char_item_t   pending_chars[$];
  line_values_t expected_lines[$];
  logic [7:0]   line_buf[$];

  int  fails;
  int  chars_sent;
  int  lines_built;
  int  lines_checked;
  int  ovf_lines;
  int  src_gap;
  int  sink_gap;
  bit  char_taken;

  // parser model state
  parse_state_t    ph;
  int              skip_n;
  longint unsigned acc;
  bit              neg;
  int              frac_n;
  bit              seen_pt;
  bit              begun;
  logic [1:0]      h_letter;
  logic [7:0]      h_number;
  logic [31:0]     h_x;
  logic [31:0]     h_y;
  logic [31:0]     h_delay;
  logic [7:0]      h_pen;
  logic [7:0]      h_laser;
  bit              l_ovf;

  function automatic void start_number(parse_state_t p);
    ph = p;
    acc = 0;
    neg = 0;
    frac_n = 0;
    seen_pt = 0;
    begun = 0;
  endfunction

  function automatic void push_digit(logic [7:0] c);
    acc = acc * 10 + (c - CH_0);
    if (acc > ACC_CAP) acc = ACC_CAP;
  endfunction

  function automatic bit blank_char(logic [7:0] c);
    return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // 1 when the character is part of the number being read
  function automatic bit take_char(logic [7:0] c, bit decimal);
    if (c >= CH_0 && c <= CH_9) begin
      begun = 1;
      if (!seen_pt) begin
        push_digit(c);
      end else if (frac_n < FRAC_DIGITS) begin
        push_digit(c);
        frac_n++;
      end
      return 1;
    end
    if (!begun) begin
      if (blank_char(c)) return 1;
      if (c == CH_PLUS || c == CH_MINUS) begin
        begun = 1;
        neg = (c == CH_MINUS);
        return 1;
      end
    end
    if (decimal && c == CH_POINT && !seen_pt) begin
      begun = 1;
      seen_pt = 1;
      return 1;
    end
    return 0;
  endfunction

  function automatic longint settle(bit decimal, longint lo, longint hi);
    longint unsigned m;
    longint v;
    m = acc;
    if (decimal) begin
      for (int k = frac_n; k < FRAC_DIGITS; k++) begin
        m = m * 10;
        if (m > ACC_CAP) m = ACC_CAP;
      end
    end
    v = neg ? -longint'(m) : longint'(m);
    if (v < lo) begin
      v = lo;
      l_ovf = 1;
    end
    if (v > hi) begin
      v = hi;
      l_ovf = 1;
    end
    return v;
  endfunction

  function automatic void after_num(int gap, parse_state_t skip_ph, parse_state_t tgt);
    if (gap <= 1) begin
      start_number(tgt);
    end else begin
      ph = skip_ph;
      skip_n = gap - 1;
    end
  endfunction

  function automatic void commit_field(parse_state_t p);
    longint v;
    case (p)
      PS_CMD: begin
        v = settle(0, 0, 255);
        ph = PS_DONE;
        if (h_letter == LETTER_G) begin
          if (v == CMD_G_MOVE) begin
            h_number = CMD_G_MOVE;
            after_num(G_GAP, PS_SKIP_X, PS_X);
          end else if (v == CMD_G_HOME) begin
            h_number = CMD_G_HOME;
          end
        end else if (h_letter == LETTER_M) begin
          if (v == CMD_M_PEN) begin
            h_number = CMD_M_PEN;
            after_num(M_GAP, PS_DONE, PS_PEN);
          end else if (v == CMD_M_LASER) begin
            h_number = CMD_M_LASER;
            after_num(M_GAP, PS_DONE, PS_LASER);
          end else if (v == CMD_M_STOP) begin
            h_number = CMD_M_STOP;
          end
        end
      end
      PS_X: begin
        h_x = 32'(settle(1, WORD_MIN, WORD_MAX));
        after_num(G_GAP, PS_SKIP_Y, PS_Y);
      end
      PS_Y: begin
        h_y = 32'(settle(1, WORD_MIN, WORD_MAX));
        after_num(G_GAP, PS_SKIP_DELAY, PS_DELAY);
      end
      PS_DELAY: begin
        h_delay = 32'(settle(0, WORD_MIN, WORD_MAX));
        ph = PS_DONE;
      end
      PS_PEN: begin
        h_pen = 8'(settle(0, 0, 255));
        ph = PS_DONE;
      end
      PS_LASER: begin
        h_laser = 8'(settle(0, 0, 255));
        ph = PS_DONE;
      end
      default: ph = PS_DONE;
    endcase
  endfunction

  function automatic void predict_char(logic [7:0] c, bit last);
    parse_state_t prev;
    line_values_t r;
    prev = ph;
    case (ph)
      PS_START: begin
        if (c == CH_G) begin
          h_letter = LETTER_G;
          start_number(PS_CMD);
        end else if (c == CH_M) begin
          h_letter = LETTER_M;
          start_number(PS_CMD);
        end else begin
          ph = PS_IGNORE;
        end
      end
      PS_CMD, PS_DELAY, PS_PEN, PS_LASER: if (!take_char(c, 0)) commit_field(ph);
      PS_X, PS_Y: if (!take_char(c, 1)) commit_field(ph);
      PS_SKIP_X, PS_SKIP_Y, PS_SKIP_DELAY: begin
        if (skip_n <= 1) begin
          skip_n = 0;
          start_number(ph == PS_SKIP_X ? PS_X : ph == PS_SKIP_Y ? PS_Y : PS_DELAY);
        end else begin
          skip_n--;
        end
      end
      default: ;
    endcase
    if (last) begin
      // a number cut off by line end counts only if it was already being read
      if (ph >= PS_CMD && ph <= PS_LASER && ph == prev) commit_field(ph);
      r.letter = h_letter;
      r.number = h_number;
      r.x = h_x;
      r.y = h_y;
      r.delay = h_delay;
      r.pen = h_pen;
      r.laser = h_laser;
      r.ovf = l_ovf;
      expected_lines.push_back(r);
      start_number(PS_START);
      skip_n = 0;
      l_ovf = 0;
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
      fails++;
    end
  endfunction

  function automatic void check_result();
    line_values_t r;
    if (expected_lines.size() == 0) begin
      $error("result item with no line pending");
      fails++;
      return;
    end
    r = expected_lines.pop_front();
    check_field("command_letter", 32'(r.letter), 32'(res_if.command_letter));
    check_field("command_number", 32'(r.number), 32'(res_if.command_number));
    check_field("target_x", r.x, res_if.target_x);
    check_field("target_y", r.y, res_if.target_y);
    check_field("aux_delay", r.delay, res_if.aux_delay);
    check_field("pen_position", 32'(r.pen), 32'(res_if.pen_position));
    check_field("laser_power", 32'(r.laser), 32'(res_if.laser_power));
    check_field("overflow", 32'(r.ovf), 32'(res_if.overflow));
    lines_checked++;
    if (r.ovf) ovf_lines++;
  endfunction

  // line building

  function automatic void put(logic [7:0] c);
    line_buf.push_back(c);
  endfunction

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endfunction

  function automatic void put_sep();
    put(($urandom_range(0, 5) == 0) ? CH_SEMI : CH_SPACE);
  endfunction

  function automatic void put_number(bit decimal);
    int r;
    int n_int;
    if ($urandom_range(0, 3) == 0)
      put($urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(9, 13)));
    r = $urandom_range(0, 3);
    if (r == 0) put(CH_PLUS);
    else if (r == 1) put(CH_MINUS);
    r = $urandom_range(0, 15);
    n_int = (r == 0) ? 0 : (r == 1) ? $urandom_range(10, 14) : $urandom_range(1, 4);
    repeat (n_int) put(CH_0 + 8'($urandom_range(0, 9)));
    if (decimal && $urandom_range(0, 2) != 0) begin
      put(CH_POINT);
      repeat ($urandom_range(0, 5)) put(CH_0 + 8'($urandom_range(0, 9)));
    end
  endfunction

  function automatic void put_move();
    int r;
    put(CH_G);
    if ($urandom_range(0, 5) == 0) put(CH_SPACE);
    r = $urandom_range(0, 5);
    if (r == 0) put_str("01");
    else if (r == 1) put_str("+1");
    else put_str("1");
    put_sep();
    put(CH_X);
    put_number(1);
    put_sep();
    put(CH_Y);
    put_number(1);
    put_sep();
    put(CH_F);
    put_number(0);
  endfunction

  function automatic void flush_line(bit hold);
    char_item_t it;
    for (int i = 0; i < line_buf.size(); i++) begin
      it.code = line_buf[i];
      it.last = (i == line_buf.size() - 1);
      it.hold = hold && (i == 0);
      pending_chars.push_back(it);
    end
    line_buf.delete();
    lines_built++;
  endfunction

  task automatic build_stimulus();
    int counted;
    int kind;
    int cut;
    bit noise;
    // directed lines
    put_str("G28");    flush_line(0);
    put_str("M4 999"); flush_line(0);
    put_str("M1-7");   flush_line(0);
    put_str("G1 X-.5"); flush_line(0);
    put_str("M10");    flush_line(0);
    put(8'h00);        flush_line(0);
    put(8'hFF);        flush_line(0);
    put_str("G5");     flush_line(0);
    counted = pending_chars.size();
    while (counted < CHAR_TARGET) begin
      noise = 0;
      kind = $urandom_range(0, 19);
      if (kind <= 6) begin
        put_move();
      end else if (kind <= 8) begin
        put_str("G28");
      end else if (kind <= 11) begin
        put_str("M1");
        put_sep();
        put_number(0);
      end else if (kind <= 13) begin
        put_str("M4");
        put_sep();
        put_number(0);
      end else if (kind == 14) begin
        put_str("M10");
      end else if (kind == 15) begin
        // letter with a number that may not be a known command
        put($urandom_range(0, 1) ? CH_G : CH_M);
        put_number(0);
        put_sep();
        put_number(0);
      end else if (kind <= 17) begin
        noise = 1;
        repeat ($urandom_range(1, 8)) put(8'($urandom_range(0, 255)));
      end else begin
        put_move();
        line_buf[$urandom_range(1, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
      end
      if (!noise && $urandom_range(0, 3) != 0)
        put(($urandom_range(0, 3) == 0) ? CH_CR : CH_LF);
      if ($urandom_range(0, 5) == 0) begin
        cut = $urandom_range(1, line_buf.size());
        while (line_buf.size() > cut) void'(line_buf.pop_back());
      end
      if (!noise) counted += line_buf.size();
      flush_line(lines_built == 30 || $urandom_range(0, 39) == 0);
    end
  endtask

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // character source
  always @(negedge clk) begin
    if (rst) begin
      chars_if.valid <= 0;
    end else if (!(chars_if.valid && !char_taken)) begin
      if (src_gap > 0) begin
        src_gap--;
        chars_if.valid <= 0;
      end else if (pending_chars.size() == 0) begin
        chars_if.valid <= 0;
      end else if (pending_chars[0].hold && expected_lines.size() != 0) begin
        chars_if.valid <= 0;
      end else if (pending_chars.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
        src_gap = $urandom_range(1, 10) - 1;
        chars_if.valid <= 0;
      end else begin
        chars_if.valid <= 1;
        chars_if.char_code <= pending_chars[0].code;
        chars_if.last_char <= pending_chars[0].last;
      end
    end
  end

  // result sink backpressure
  always @(negedge clk) begin
    if (rst) begin
      res_if.ready <= 0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      res_if.ready <= 0;
    end else if (pending_chars.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
      sink_gap = $urandom_range(1, 10) - 1;
      res_if.ready <= 0;
    end else begin
      res_if.ready <= 1;
    end
  end

  // monitor: check results, then feed accepted characters to the model
  always @(posedge clk) begin
    if (rst) begin
      char_taken = 0;
    end else begin
      if (res_if.valid && res_if.ready) check_result();
      char_taken = chars_if.valid && chars_if.ready;
      if (char_taken) begin
        predict_char(chars_if.char_code, chars_if.last_char);
        void'(pending_chars.pop_front());
        chars_sent++;
      end
    end
  end

  initial begin
    rst = 1;
    chars_if.valid = 0;
    chars_if.char_code = 0;
    chars_if.last_char = 0;
    res_if.ready = 0;
    fails = 0;
    chars_sent = 0;
    lines_built = 0;
    lines_checked = 0;
    ovf_lines = 0;
    src_gap = 0;
    sink_gap = 0;
    char_taken = 0;
    skip_n = 0;
    h_letter = LETTER_NONE;
    h_number = 0;
    h_x = 0;
    h_y = 0;
    h_delay = 0;
    h_pen = 0;
    h_laser = 0;
    l_ovf = 0;
    start_number(PS_START);
    build_stimulus();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    while (pending_chars.size() != 0) @(posedge clk);
    while (expected_lines.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Sent %0d characters in %0d lines; checked %0d results, %0d with overflow.",
             chars_sent, lines_built, lines_checked, ovf_lines);
    if (fails == 0 && expected_lines.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Timed out with %0d characters and %0d results outstanding.",
             pending_chars.size(), expected_lines.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire

FILE: gcode_line_parser_core.f
hw/rtl/gcl_pkg.sv
hw/rtl/gcl_char_if.sv
hw/rtl/gcl_result_if.sv
hw/rtl/gcl_scanner.sv
hw/rtl/gcl_commit.sv
hw/rtl/gcode_line_parser_core.sv
tb/gcode_line_parser_core_tb.sv
